### src/tone_sequence_player_macros.svh
// ----------------------------------------------------------------------------
// tone sequence player assertion macros
// shared concurrent assertion helpers for the tone sequence player
// ----------------------------------------------------------------------------
`ifndef TONE_SEQUENCE_PLAYER_MACROS_SVH
`define TONE_SEQUENCE_PLAYER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TSP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tone sequence player check failed");

// next-cycle implication, disabled during reset
`define TSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tone sequence player check failed");

`endif

### src/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// types and constants of the tone sequence player
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

   // melody table
   localparam int MAX_PAIRS = 64;
   localparam int ADDR_W    = 6;
   localparam int LEN_W     = 7;

   // commands
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_PLAY = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;
   localparam logic [1:0] CMD_TICK = 2'd3;

   // register indexes
   localparam logic CSR_SONG_LENGTH = 1'b0;
   localparam logic CSR_PLAY_ONCE   = 1'b1;

   // tone mapping
   localparam logic [15:0] FREQ_ALIAS     = 16'd1;
   localparam logic [15:0] FREQ_ALIAS_HZ  = 16'd3150;
   localparam logic [15:0] FREQ_MIN       = 16'd16;
   localparam logic [15:0] FREQ_MAX       = 16'd20000;
   localparam int          DIV_W          = 20;
   localparam logic [DIV_W-1:0] TIMER_HZ  = 20'd1000000;
   localparam int          DIVISOR_W      = 15;
   localparam int          DIV_CNT_W      = 5;

   // reset tone
   localparam logic [15:0] PERIOD_RESET  = 16'd320;
   localparam logic [14:0] COMPARE_RESET = 15'd103;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] entry_index;
      logic [15:0]       entry_freq;
      logic [15:0]       entry_duration;
   } tsp_req_type;

   typedef struct packed {
      logic        tone_on;
      logic [15:0] period;
      logic [14:0] compare;
      logic        reload_pulse;
      logic        busy_res;
   } tsp_rsp_type;

   typedef struct packed {
      logic [15:0] freq;
      logic [15:0] duration;
   } tsp_entry_type;

endpackage

`default_nettype wire

### src/tone_sequence_player.sv
// ----------------------------------------------------------------------------
// tone_sequence_player
// melody sequencer over a frequency/duration table with a serial period divider
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one response, shown on rsp_data for one cycle with rsp_valid high;
// the receiver cannot stall it, so it must sample it in that cycle. Loads,
// stops, ignored plays and plain countdown ticks go straight from accept to
// the response. A request that starts a new pair reads the melody memory into
// a registered read port; an audible tone then runs the restoring divider for
// 1000000 / freq, one quotient bit a cycle, before the response; a silent pair
// goes from the read straight to the response. The divider sets the worst case.
// Memory entries are valid only once loaded; the memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_sequence_player (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  tsp_pkg::tsp_req_type req_data,
   output logic                 rsp_valid,
   output tsp_pkg::tsp_rsp_type rsp_data,
   input  wire                  csr_we,
   input  wire                  csr_index,
   input  wire [tsp_pkg::LEN_W-1:0] csr_wdata
);

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   // configuration
   logic [tsp_pkg::LEN_W-1:0] song_length_ff;
   logic                      play_once_ff;

   // player state
   state_type                  state_ff, state_in;
   logic                       playing_ff, playing_in;
   logic [tsp_pkg::ADDR_W-1:0] next_pair_ff, next_pair_in;
   logic [tsp_pkg::ADDR_W-1:0] slot_ff, slot_in;
   logic [15:0]                remaining_ff, remaining_in;
   logic                       tone_on_ff, tone_on_in;
   logic [15:0]                period_ff, period_in;
   logic [14:0]                compare_ff, compare_in;
   logic                       pulse_ff, pulse_in;

   // divider
   logic [tsp_pkg::DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [tsp_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [tsp_pkg::DIV_W-1:0]     dq_ff, dq_in;
   logic [tsp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [tsp_pkg::DIVISOR_W:0]   trial;
   logic                          q_bit;
   logic                          div_last;
   logic [tsp_pkg::DIV_W-1:0]     dq_step;

   // melody memory
   tsp_pkg::tsp_entry_type     song_mem [tsp_pkg::MAX_PAIRS];
   tsp_pkg::tsp_entry_type     rd_data_ff;
   logic                       rd_en;
   logic [tsp_pkg::ADDR_W-1:0] rd_addr;
   logic                       wr_en;

   logic                       accept;
   logic [tsp_pkg::LEN_W-1:0]  eff_len;
   logic [tsp_pkg::LEN_W-1:0]  slot_plus;
   logic [15:0]                freq_eff;
   logic                       audible;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // song length saturates at the table size
   assign eff_len = (song_length_ff > tsp_pkg::LEN_W'(tsp_pkg::MAX_PAIRS)) ?
                    tsp_pkg::LEN_W'(tsp_pkg::MAX_PAIRS) : song_length_ff;

   // pair after the one being started, wrapping at the song length
   assign slot_plus = {1'b0, slot_ff} + tsp_pkg::LEN_W'(1);

   // frequency alias and audible range
   assign freq_eff = (rd_data_ff.freq == tsp_pkg::FREQ_ALIAS) ?
                     tsp_pkg::FREQ_ALIAS_HZ : rd_data_ff.freq;
   assign audible  = (freq_eff >= tsp_pkg::FREQ_MIN) && (freq_eff <= tsp_pkg::FREQ_MAX);

   // one restoring step: bring in the next dividend bit, try the subtract
   assign trial    = {rem_ff, dq_ff[tsp_pkg::DIV_W-1]};
   assign q_bit    = (trial >= {1'b0, divisor_ff});
   assign dq_step  = {dq_ff[tsp_pkg::DIV_W-2:0], q_bit};
   assign div_last = (cnt_ff == tsp_pkg::DIV_CNT_W'(tsp_pkg::DIV_W - 1));

   // load writes only while idle and not playing
   assign wr_en = accept && (req_data.cmd == tsp_pkg::CMD_LOAD) && !playing_ff;

   always_comb begin
      state_in     = state_ff;
      playing_in   = playing_ff;
      next_pair_in = next_pair_ff;
      slot_in      = slot_ff;
      remaining_in = remaining_ff;
      tone_on_in   = tone_on_ff;
      period_in    = period_ff;
      compare_in   = compare_ff;
      pulse_in     = pulse_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      cnt_in       = cnt_ff;
      rd_en        = 1'b0;
      rd_addr      = next_pair_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pulse_in = 1'b0;
               state_in = ST_RESP;
               case (req_data.cmd)
                  tsp_pkg::CMD_LOAD: begin
                     // memory write handled below
                  end
                  tsp_pkg::CMD_PLAY: begin
                     if (!playing_ff) begin
                        tone_on_in = 1'b0;
                        if (eff_len != '0) begin
                           playing_in = 1'b1;
                           rd_en      = 1'b1;
                           rd_addr    = '0;
                           slot_in    = '0;
                           state_in   = ST_READ;
                        end
                     end
                  end
                  tsp_pkg::CMD_STOP: begin
                     playing_in = 1'b0;
                     tone_on_in = 1'b0;
                  end
                  default: begin
                     // millisecond tick
                     if (playing_ff) begin
                        if (remaining_ff > 16'd1) begin
                           remaining_in = remaining_ff - 16'd1;
                        end else if ((next_pair_ff == '0) && play_once_ff) begin
                           playing_in   = 1'b0;
                           remaining_in = '0;
                           tone_on_in   = 1'b0;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = next_pair_ff;
                           slot_in  = next_pair_ff;
                           state_in = ST_READ;
                        end
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            remaining_in = rd_data_ff.duration;
            next_pair_in = (slot_plus >= eff_len) ? '0 : slot_plus[tsp_pkg::ADDR_W-1:0];
            if (audible) begin
               divisor_in = freq_eff[tsp_pkg::DIVISOR_W-1:0];
               rem_in     = '0;
               dq_in      = tsp_pkg::TIMER_HZ;
               cnt_in     = '0;
               state_in   = ST_DIV;
            end else begin
               tone_on_in = 1'b0;
               state_in   = ST_RESP;
            end
         end
         ST_DIV: begin
            rem_in = q_bit ? trial[tsp_pkg::DIVISOR_W-1:0] - divisor_ff :
                             trial[tsp_pkg::DIVISOR_W-1:0];
            dq_in  = dq_step;
            cnt_in = cnt_ff + tsp_pkg::DIV_CNT_W'(1);
            if (div_last) begin
               // quotient is at most 62500, so 16 bits carry it all
               tone_on_in = 1'b1;
               period_in  = dq_step[15:0];
               compare_in = dq_step[15:1];
               pulse_in   = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         playing_ff     <= 1'b0;
         next_pair_ff   <= '0;
         slot_ff        <= '0;
         remaining_ff   <= '0;
         tone_on_ff     <= 1'b0;
         period_ff      <= tsp_pkg::PERIOD_RESET;
         compare_ff     <= tsp_pkg::COMPARE_RESET;
         pulse_ff       <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         playing_ff     <= playing_in;
         next_pair_ff   <= next_pair_in;
         slot_ff        <= slot_in;
         remaining_ff   <= remaining_in;
         tone_on_ff     <= tone_on_in;
         period_ff      <= period_in;
         compare_ff     <= compare_in;
         pulse_ff       <= pulse_in;
         cnt_ff         <= cnt_in;
      end
   end

   // divider datapath, no reset needed
   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         song_length_ff <= '0;
         play_once_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            tsp_pkg::CSR_SONG_LENGTH: song_length_ff <= csr_wdata;
            tsp_pkg::CSR_PLAY_ONCE:   play_once_ff   <= csr_wdata[0];
            default:                  play_once_ff   <= play_once_ff;
         endcase
      end
   end

   // melody memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         song_mem[req_data.entry_index] <= '{freq: req_data.entry_freq,
                                             duration: req_data.entry_duration};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= song_mem[rd_addr];
      end
   end

   // response shown for the single cycle of the response state
   assign rsp_valid             = (state_ff == ST_RESP);
   assign rsp_data.tone_on      = tone_on_ff;
   assign rsp_data.period       = period_ff;
   assign rsp_data.compare      = compare_ff;
   assign rsp_data.reload_pulse = pulse_ff;
   assign rsp_data.busy_res     = playing_ff;

`include "tone_sequence_player_macros.svh"

   // a response never appears while the block looks idle
   `TSP_ASSERT_IMPL(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   // a reload comes only with an audible tone during play
   `TSP_ASSERT_IMPL(a_pulse_audible, clock, reset, rsp_valid && rsp_data.reload_pulse,
                    rsp_data.tone_on && rsp_data.busy_res)
   // the last divider step hands over to the response
   `TSP_ASSERT_NEXT(a_div_to_rsp, clock, reset, (state_ff == ST_DIV) && div_last, rsp_valid)
   // an accepted request keeps the block busy in the next cycle
   `TSP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

endmodule

`default_nettype wire
